/* sv/sha256_stream_hasher_defines.svh */
// Assertion macros shared by the SHA-256 stream hasher RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; imported by the schedule, round and top modules.
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  hash_t;   // index 0 = a / H0

  // input item kinds (in_tuser)
  localparam logic MODE_BYTE   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam hash_t IV_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // schedule window control
  typedef struct packed {
    logic       push;       // shift one byte into the block
    logic [7:0] push_data;
    logic       step;       // advance message schedule one round
  } sched_ctl_t;

  // round unit control
  typedef struct packed {
    logic load;             // copy chaining words into a..h
    logic step;             // run one round
  } round_ctl_t;

  function automatic word_t big_s0(input word_t x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t sml_s0(input word_t x);
    sml_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sml_s1(input word_t x);
    sml_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t f_ch(input word_t e, input word_t f, input word_t g);
    f_ch = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t f_maj(input word_t a, input word_t b, input word_t c);
    f_maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

/* sv/sha256_stream_hasher.sv */
// Top level of the streaming SHA-256 hasher: sequencer, chaining words, counters.
// Depends on sha256_pkg, sha256_sched, sha256_round, sha256_stream_hasher_defines.svh.
//
//  channel | dir | tdata                                  | tuser      | tlast
//  --------+-----+----------------------------------------+------------+-----------
//  in_     | in  | [7:0] data_byte                        | [0] mode   | -
//  out_    | out | [31:0] digest_word, [34:32] word_index | -          | last
//
// Sequence: message bytes are taken back to back while idle; the 64th byte of a block
// starts 64 rounds and then the feed-forward, on the single shared round unit.
// Finish: pad bytes (0x80, zeros to offset 56, 8 length bytes) go in one by one, each
// compressed block (one or two) runs its rounds and feed-forward, then 8 digest transfers.
// Reset: synchronous, active low; chaining words return to the initial hash.
// Stalls: in_tready is low from a block's last byte or a finish until the
// block is back in idle; a stalled digest word holds on out_tdata.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        out_tlast
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message bytes
  localparam logic [2:0] ST_PAD   = 3'd1;  // 0x80 then zeros up to offset 56
  localparam logic [2:0] ST_LEN   = 3'd2;  // 64-bit big-endian bit length
  localparam logic [2:0] ST_ROUND = 3'd3;  // 64 compression rounds
  localparam logic [2:0] ST_ADD   = 3'd4;  // feed-forward into chaining words
  localparam logic [2:0] ST_OUT   = 3'd5;  // emit digest words

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;      // bytes held in the block
  logic [63:0] msg_cnt_r, msg_cnt_nxt;
  logic [63:0] bits_r, bits_nxt;      // length field, shifted out MSB first
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;        // finish in progress
  logic        first_r, first_nxt;    // next pad byte is the 0x80 marker
  logic        len_done_r, len_done_nxt;
  hash_t       chain_r, chain_nxt;

  sched_ctl_t  sctl;
  round_ctl_t  rctl;
  word_t       w_cur;
  hash_t       vars;
  logic        in_xfer;
  logic        out_xfer;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = (idx_r == 3'd7);
  assign out_tdata  = {5'd0, idx_r, chain_r[0]};
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  sha256_round u_round (
    .clk   (clk),
    .ctl   (rctl),
    .chain (chain_r),
    .w_cur (w_cur),
    .k_cur (round_k(rnd_r)),
    .vars  (vars)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    msg_cnt_nxt  = msg_cnt_r;
    bits_nxt     = bits_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    fin_nxt      = fin_r;
    first_nxt    = first_r;
    len_done_nxt = len_done_r;
    chain_nxt    = chain_r;
    sctl         = '0;
    rctl         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == MODE_FINISH) begin
            bits_nxt  = {msg_cnt_r[60:0], 3'b000};  // byte count times 8, wraps
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            state_nxt = ST_PAD;
          end else begin
            sctl.push      = 1'b1;
            sctl.push_data = in_tdata;
            msg_cnt_nxt    = msg_cnt_r + 64'd1;
            fill_nxt       = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              rctl.load = 1'b1;
              rnd_nxt   = 6'd0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end

      ST_PAD: begin
        sctl.push      = 1'b1;
        sctl.push_data = first_r ? 8'h80 : 8'h00;
        first_nxt      = 1'b0;
        fill_nxt       = fill_r + 6'd1;
        if (fill_r == 6'd55) begin
          state_nxt = ST_LEN;
        end else if (fill_r == 6'd63) begin
          // marker spilled past offset 56: compress, then pad a second block
          rctl.load = 1'b1;
          rnd_nxt   = 6'd0;
          state_nxt = ST_ROUND;
        end
      end

      ST_LEN: begin
        sctl.push      = 1'b1;
        sctl.push_data = bits_r[63:56];
        bits_nxt       = {bits_r[55:0], 8'h00};
        fill_nxt       = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          len_done_nxt = 1'b1;
          rctl.load    = 1'b1;
          rnd_nxt      = 6'd0;
          state_nxt    = ST_ROUND;
        end
      end

      ST_ROUND: begin
        sctl.step = 1'b1;
        rctl.step = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        for (int j = 0; j < 8; j++) begin
          chain_nxt[j] = chain_r[j] + vars[j];
        end
        if (len_done_r) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_xfer) begin
          chain_nxt = {chain_r[0], chain_r[7:1]};  // next word to position 0
          idx_nxt   = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            chain_nxt    = IV_HASH;
            msg_cnt_nxt  = 64'd0;
            fin_nxt      = 1'b0;
            len_done_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= 6'd0;
      msg_cnt_r  <= 64'd0;
      rnd_r      <= 6'd0;
      idx_r      <= 3'd0;
      fin_r      <= 1'b0;
      first_r    <= 1'b0;
      len_done_r <= 1'b0;
      chain_r    <= IV_HASH;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      msg_cnt_r  <= msg_cnt_nxt;
      rnd_r      <= rnd_nxt;
      idx_r      <= idx_nxt;
      fin_r      <= fin_nxt;
      first_r    <= first_nxt;
      len_done_r <= len_done_nxt;
      chain_r    <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

  // the last round (rnd_r 63) is always followed by the feed-forward
  `SHA_ASSERT_NEXT(a_round_end, (state_r == ST_ROUND) && (rnd_r == 6'd63), state_r == ST_ADD, "round count overran")
  // length bytes only ever go to offsets 56..63
  `SHA_ASSERT_NOW(a_len_slot, state_r == ST_LEN, fill_r[5:3] == 3'b111, "length byte out of place")
  // digest is only emitted after the length block was compressed
  `SHA_ASSERT_NOW(a_out_final, out_tvalid, len_done_r && fin_r && (fill_r == 6'd0), "digest before final block")
  // after the last digest word the block is idle with a fresh message count
  `SHA_ASSERT_NEXT(a_out_done, out_xfer && out_tlast, (state_r == ST_IDLE) && (msg_cnt_r == 64'd0), "no return to idle")

endmodule

/* sv/sha256_sched.sv */
// Block buffer and rolling message schedule (one 512-bit shift line).
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_sched import sha256_pkg::*; (
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      w_cur
);

  // word j of the window sits at blk_r[511-32*j -: 32]; word 0 is W[t]
  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  word_t        w_new;

  assign w_cur = blk_r[511:480];

  // W[t+16] = s1(W[t+14]) + W[t+9] + s0(W[t+1]) + W[t]
  assign w_new = sml_s1(blk_r[63:32]) + blk_r[223:192] + sml_s0(blk_r[479:448])
               + blk_r[511:480];

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.push) begin
      blk_nxt = {blk_r[503:0], ctl.push_data};
    end else if (ctl.step) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

/* sv/sha256_round.sv */
// Shared compression round unit: working variables a..h and one round per step.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_round import sha256_pkg::*; (
  input  logic       clk,
  input  round_ctl_t ctl,
  input  hash_t      chain,
  input  word_t      w_cur,
  input  word_t      k_cur,
  output hash_t      vars
);

  hash_t vars_r;
  hash_t vars_nxt;
  word_t t1;
  word_t t2;

  assign vars = vars_r;

  assign t1 = vars_r[7] + big_s1(vars_r[4]) + f_ch(vars_r[4], vars_r[5], vars_r[6])
            + k_cur + w_cur;
  assign t2 = big_s0(vars_r[0]) + f_maj(vars_r[0], vars_r[1], vars_r[2]);

  always_comb begin
    vars_nxt = vars_r;
    if (ctl.load) begin
      vars_nxt = chain;
    end else if (ctl.step) begin
      vars_nxt[7] = vars_r[6];
      vars_nxt[6] = vars_r[5];
      vars_nxt[5] = vars_r[4];
      vars_nxt[4] = vars_r[3] + t1;
      vars_nxt[3] = vars_r[2];
      vars_nxt[2] = vars_r[1];
      vars_nxt[1] = vars_r[0];
      vars_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
  end

endmodule
